// File: sv/rgb565_flame_smoke_frame_scorer_defines.svh
// Assertion helpers for the frame scorer.
`ifndef RGB565_FLAME_SMOKE_FRAME_SCORER_DEFINES_SVH
`define RGB565_FLAME_SMOKE_FRAME_SCORER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define RFS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame scorer check failed");
// Next-cycle implication.
`define RFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame scorer check failed");
`else
`define RFS_ASSERT_IMPL(name, ante, cons)
`define RFS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: sv/rfs_pkg.sv
package rfs_pkg;

  localparam int unsigned MAX_FRAME_PIXELS = 131072;
  // Counter must hold MAX_FRAME_PIXELS itself.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  // Hits times ten.
  localparam int unsigned DVD_W = CNT_W + 4;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned STEP_W = $clog2(FRAC_W + 1);

  localparam logic [FRAC_W-1:0] FLAME_CAP = 16'd64880;
  localparam logic [FRAC_W-1:0] SMOKE_CAP = 16'd62259;

  typedef struct packed {
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] flame;
    logic [CNT_W-1:0] smoke;
    logic             overflowed;
  } rfs_cnt_t;

  typedef struct packed {
    logic inc;
    logic clear;
  } rfs_cnt_ctrl_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } rfs_div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [FRAC_W-1:0] quo;
  } rfs_div_rsp_t;

endpackage

// File: sv/rfs_counter.sv
module rfs_counter import rfs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rfs_cnt_ctrl_t ctrl_i,
  input  logic [15:0]   pixel_i,
  output rfs_cnt_t      cnt_o
);

  logic [4:0] red;
  logic [5:0] green;
  logic [4:0] blue;
  logic       hot;
  logic       smoky;
  rfs_cnt_t   cnt_d;
  rfs_cnt_t   cnt_q;

  assign red   = pixel_i[15:11];
  assign green = pixel_i[10:5];
  assign blue  = pixel_i[4:0];

  assign hot   = (red >= 5'd20) && (green >= 6'd10) && (green <= 6'd30) && (blue <= 5'd10);
  assign smoky = (red >= 5'd10) && (red <= 5'd24) && (green >= 6'd10) && (green <= 6'd32) &&
                 (blue >= 5'd10) && (blue <= 5'd24);

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      cnt_d = '0;
    end else if (ctrl_i.inc) begin
      if (cnt_q.seen >= CNT_W'(MAX_FRAME_PIXELS)) begin
        // Frame too long: hold the counts, flag it.
        cnt_d.overflowed = 1'b1;
      end else begin
        cnt_d.seen = cnt_q.seen + CNT_W'(1);
        if (hot) begin
          cnt_d.flame = cnt_q.flame + CNT_W'(1);
        end
        if (smoky) begin
          cnt_d.smoke = cnt_q.smoke + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// File: sv/rfs_divider.sv
module rfs_divider import rfs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rfs_div_req_t req_i,
  output rfs_div_rsp_t rsp_o
);

  // Restoring divider: one quotient bit per cycle, FRAC_W fraction bits.
  logic              busy_d, busy_q;
  logic              done_d, done_q;
  logic [STEP_W-1:0] steps_d, steps_q;
  logic              sat_d, sat_q;
  logic [CNT_W-1:0]  div_d, div_q;
  logic [CNT_W-1:0]  rem_d, rem_q;
  logic [FRAC_W-1:0] quo_d, quo_q;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    steps_d = steps_q;
    sat_d   = sat_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (req_i.start) begin
      div_d = req_i.divisor;
      rem_d = req_i.dividend[CNT_W-1:0];
      quo_d = '0;
      if ((req_i.divisor == '0) || (req_i.dividend >= DVD_W'(req_i.divisor))) begin
        // Quotient would not fit the fraction: saturate, or zero for an empty count.
        sat_d   = req_i.divisor != '0;
        busy_d  = 1'b0;
        done_d  = 1'b1;
        steps_d = '0;
      end else begin
        sat_d   = 1'b0;
        busy_d  = 1'b1;
        steps_d = STEP_W'(FRAC_W);
      end
    end else if (busy_q) begin
      rem_d   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d   = {quo_q[FRAC_W-2:0], ge};
      steps_d = steps_q - STEP_W'(1);
      if (steps_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
    div_q <= div_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: sv/rgb565_flame_smoke_frame_scorer.sv
// Flame / smoke scorer for an RGB565 pixel stream.
// Input channel (in_valid_i / in_ready_o): one pixel per item, with last_pixel_i
// marking the final pixel of a frame. Pixels that are not last are taken one per
// cycle while in_ready_o is high and only update the frame counters.
// Output channel (out_valid_o / out_ready_i): one result per frame, holding both
// Q0.16 scores, the two detection flags and the too-long flag.
// After the last pixel, one shared restoring divider produces the flame score and
// then the smoke score, one quotient bit per cycle. In_ready_o stays low from the
// last pixel until the result is loaded into the output register (two divisions
// of up to 16 steps each, plus sequencing).
// The result sits in an output register; a stalled receiver does not block the next
// frame's pixels, only the hand-off of the following result, and the block waits
// with in_ready_o low until that register frees up.
// Reset clears the counters, the sequencer and the output valid.
// Pixels past the frame bound are not counted and set frame_too_long_o.
`include "rgb565_flame_smoke_frame_scorer_defines.svh"

module rgb565_flame_smoke_frame_scorer import rfs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pixel_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] flame_score_o,
  output logic [15:0] smoke_score_o,
  output logic        flame_detected_o,
  output logic        smoke_detected_o,
  output logic        frame_too_long_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FSTART = 3'd1;
  localparam logic [2:0] S_FWAIT  = 3'd2;
  localparam logic [2:0] S_SSTART = 3'd3;
  localparam logic [2:0] S_SWAIT  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]        state_d, state_q;
  logic              in_acc;
  logic              load_out;
  rfs_cnt_ctrl_t     cnt_ctrl;
  rfs_cnt_t          cnt;
  rfs_div_req_t      div_req;
  rfs_div_rsp_t      div_rsp;
  logic [FRAC_W-1:0] score;
  logic [FRAC_W-1:0] flame_d, flame_q;
  logic [DVD_W-1:0]  flame_x10;
  logic [DVD_W-1:0]  smoke_x6;
  logic [CNT_W+6:0]  flame_x100;
  logic [CNT_W+2:0]  seen_x7;
  logic [CNT_W+3:0]  smoke_x12;
  logic              flame_hit;
  logic              smoke_hit;

  logic              out_valid_q;
  logic [FRAC_W-1:0] out_flame_q;
  logic [FRAC_W-1:0] out_smoke_q;
  logic              out_fdet_q;
  logic              out_sdet_q;
  logic              out_long_q;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign cnt_ctrl.inc   = in_acc;
  assign cnt_ctrl.clear = load_out;

  rfs_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cnt_ctrl),
    .pixel_i (pixel_i),
    .cnt_o   (cnt)
  );

  assign flame_x10 = (DVD_W'(cnt.flame) << 3) + (DVD_W'(cnt.flame) << 1);
  assign smoke_x6  = (DVD_W'(cnt.smoke) << 2) + (DVD_W'(cnt.smoke) << 1);

  assign div_req.start    = (state_q == S_FSTART) || (state_q == S_SSTART);
  assign div_req.dividend = (state_q == S_FSTART) ? flame_x10 : smoke_x6;
  assign div_req.divisor  = cnt.seen;

  rfs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Cap the quotient; the cap depends on which score is in flight.
  always_comb begin
    unique case (state_q)
      S_FWAIT: begin
        score = (div_rsp.sat || (div_rsp.quo > FLAME_CAP)) ? FLAME_CAP : div_rsp.quo;
      end
      default: begin
        score = (div_rsp.sat || (div_rsp.quo > SMOKE_CAP)) ? SMOKE_CAP : div_rsp.quo;
      end
    endcase
  end

  // Exact threshold tests: 100*hot >= 7*count and 12*smoky >= count.
  assign flame_x100 = ((CNT_W+7)'(cnt.flame) << 6) + ((CNT_W+7)'(cnt.flame) << 5) +
                      ((CNT_W+7)'(cnt.flame) << 2);
  assign seen_x7    = ((CNT_W+3)'(cnt.seen) << 3) - (CNT_W+3)'(cnt.seen);
  assign smoke_x12  = ((CNT_W+4)'(cnt.smoke) << 3) + ((CNT_W+4)'(cnt.smoke) << 2);
  assign flame_hit  = (cnt.seen != '0) && (flame_x100 >= (CNT_W+7)'(seen_x7));
  assign smoke_hit  = (cnt.seen != '0) && (smoke_x12 >= (CNT_W+4)'(cnt.seen));

  always_comb begin
    state_d = state_q;
    flame_d = flame_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last_pixel_i) begin
          state_d = S_FSTART;
        end
      end
      S_FSTART: state_d = S_FWAIT;
      S_FWAIT: begin
        if (div_rsp.done) begin
          flame_d = score;
          state_d = S_SSTART;
        end
      end
      S_SSTART: state_d = S_SWAIT;
      S_SWAIT: begin
        if (div_rsp.done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The divider holds the smoke quotient while the result waits in S_DONE.
  always_ff @(posedge clk_i) begin
    flame_q <= flame_d;
    if (load_out) begin
      out_flame_q <= flame_q;
      out_smoke_q <= score;
      out_fdet_q  <= flame_hit;
      out_sdet_q  <= smoke_hit;
      out_long_q  <= cnt.overflowed;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flame_score_o    = out_flame_q;
  assign smoke_score_o    = out_smoke_q;
  assign flame_detected_o = out_fdet_q;
  assign smoke_detected_o = out_sdet_q;
  assign frame_too_long_o = out_long_q;

  `RFS_ASSERT_NEXT(a_busy_after_last, in_acc && last_pixel_i, !in_ready_o)
  `RFS_ASSERT_IMPL(a_hits_le_seen, 1'b1, (cnt.flame <= cnt.seen) && (cnt.smoke <= cnt.seen))
  `RFS_ASSERT_IMPL(a_seen_bound, 1'b1, cnt.seen <= CNT_W'(MAX_FRAME_PIXELS))
  `RFS_ASSERT_IMPL(a_score_caps, out_valid_o,
                   (flame_score_o <= FLAME_CAP) && (smoke_score_o <= SMOKE_CAP))

endmodule
